>>> hdl/smma_pkg.sv
package smma_pkg;

    localparam int MAX_N   = 8;
    localparam int IDX_W   = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CNT_W   = $clog2(MAX_N + 1);
    localparam int ADDR_W  = $clog2(MAX_N * MAX_N);
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + IDX_W;
    localparam int PA_W    = DATA_W + ACC_W;
    localparam int T_W     = PA_W + 1;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_LOAD_C = 2'd2;
    localparam logic [1:0] CMD_START  = 2'd3;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;

    // operand token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         k;
        logic signed [DATA_W-1:0] a;
    } t_tok;

    // finished dot product of one cell
    typedef struct packed {
        logic                    done;
        logic                    last;
        logic [IDX_W-1:0]        row;
        logic signed [ACC_W-1:0] acc;
    } t_res;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_out;

    function automatic logic [ADDR_W-1:0] elem_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        logic [ADDR_W+IDX_W:0] v;
        v = ADDR_W'(MAX_N) * r + c;
        return v[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/smma_ram.sv
module smma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/smma_cell.sv
module smma_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [smma_pkg::IDX_W-1:0] i_col,
    input  logic [smma_pkg::CNT_W-1:0] i_n,
    input  smma_pkg::t_tok         i_tok,
    output smma_pkg::t_tok         o_tok,
    input  logic                   i_bwe,
    input  logic [smma_pkg::IDX_W-1:0] i_baddr,
    input  logic [smma_pkg::DATA_W-1:0] i_bdata,
    output smma_pkg::t_res         o_res
);
    import smma_pkg::*;

    localparam int BD = 1 << IDX_W;

    t_tok r_tok;
    logic [DATA_W-1:0] b_rdata;
    logic signed [PROD_W-1:0] r_prod;
    logic r_pv, r_pfirst, r_plast, r_pend;
    logic [IDX_W-1:0] r_prow;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    t_res r_res;
    logic active;
    logic [IDX_W-1:0] n_m1;

    // column of b, addressed by row
    smma_ram #(.WIDTH(DATA_W), .DEPTH(BD)) u_bcol (
        .i_clk  (i_clk),
        .i_we   (i_bwe),
        .i_waddr(i_baddr),
        .i_wdata(i_bdata),
        .i_re   (i_en),
        .i_raddr(i_tok.k),
        .o_rdata(b_rdata)
    );

    assign active = CNT_W'(i_col) < i_n;
    assign n_m1   = IDX_W'(i_n - CNT_W'(1));

    always_comb begin
        n_acc = r_pfirst ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_pv        <= 1'b0;
            r_res.done  <= 1'b0;
        end else if (i_en) begin
            r_tok    <= i_tok;
            r_pv     <= r_tok.valid && active;
            r_pfirst <= r_tok.first;
            r_plast  <= r_tok.last;
            r_prow   <= r_tok.row;
            r_pend   <= (r_tok.row == n_m1) && (i_col == n_m1);
            r_prod   <= r_tok.a * $signed(b_rdata);
            if (r_pv) begin
                r_acc <= n_acc;
            end
            r_res.done <= r_pv && r_plast;
            r_res.last <= r_pend;
            r_res.row  <= r_prow;
            r_res.acc  <= n_acc;
        end
    end

    assign o_tok = r_tok;
    assign o_res = r_res;
endmodule

>>> hdl/smma_post.sv
module smma_post (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  smma_pkg::t_res [smma_pkg::MAX_N-1:0] i_res,
    input  logic signed [smma_pkg::DATA_W-1:0]   i_alpha,
    input  logic signed [smma_pkg::DATA_W-1:0]   i_beta,
    output logic [smma_pkg::ADDR_W-1:0]          o_c_raddr,
    input  logic [smma_pkg::DATA_W-1:0]          i_c_rdata,
    output logic                                 o_c_we,
    output logic [smma_pkg::ADDR_W-1:0]          o_c_waddr,
    output logic [smma_pkg::DATA_W-1:0]          o_c_wdata,
    output smma_pkg::t_out                       o_out
);
    import smma_pkg::*;

    t_res sel;
    logic [IDX_W-1:0] sel_col;
    logic r1_v, r1_last, r2_v, r2_last;
    logic [IDX_W-1:0] r1_row, r1_col, r2_row, r2_col;
    logic signed [ACC_W-1:0] r1_acc;
    logic signed [PA_W-1:0] r2_pa;
    logic signed [PROD_W-1:0] r2_pc;
    logic signed [T_W-1:0] t_sum, t_q;
    logic signed [DATA_W-1:0] sat;
    t_out r_out;

    // cells finish one after another, so at most one done per cycle
    always_comb begin
        sel = '0;
        sel_col = '0;
        for (int j = 0; j < MAX_N; j++) begin
            if (i_res[j].done) begin
                sel = i_res[j];
                sel_col = IDX_W'(j);
            end
        end
    end

    assign o_c_raddr = elem_addr(sel.row, sel_col);

    always_comb begin
        t_sum = T_W'(r2_pa) + (T_W'(r2_pc) <<< 8);
        t_q   = t_sum >>> 16;
        if (t_q > T_W'(32767)) begin
            sat = 16'sd32767;
        end else if (t_q < -T_W'(32768)) begin
            sat = -16'sd32768;
        end else begin
            sat = t_q[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= sel.done;
            r1_last <= sel.last;
            r1_row  <= sel.row;
            r1_col  <= sel_col;
            r1_acc  <= sel.acc;
            r2_v    <= r1_v;
            r2_last <= r1_last;
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_pa   <= i_alpha * r1_acc;
            r2_pc   <= i_beta * $signed(i_c_rdata);
            r_out.valid <= r2_v;
            r_out.last  <= r2_last;
            r_out.row   <= r2_row;
            r_out.col   <= r2_col;
            r_out.value <= sat;
        end
    end

    assign o_c_we    = i_en && r2_v;
    assign o_c_waddr = elem_addr(r2_row, r2_col);
    assign o_c_wdata = sat;
    assign o_out     = r_out;
endmodule

>>> hdl/scaled_matrix_multiply_accumulate_core.sv
// load items are accepted back to back while no compute is in flight
// a start item is accepted and then holds off input until the last result
// is taken: operands stream row by row through the chain of n mac cells, and
// results come one per cycle while the receiver does not stall
// synchronous active-low reset clears control, presets config; matrix stores are not cleared
module scaled_matrix_multiply_accumulate_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_row_index,
    input  logic [2:0]  i_col_index,
    input  logic signed [15:0] i_element_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic signed [15:0] o_out_value,
    output logic        o_out_last
);
    import smma_pkg::*;

    logic [3:0] r_size;
    logic signed [DATA_W-1:0] r_alpha, r_beta;
    logic r_busy, r_iss;
    logic [IDX_W-1:0] r_i, r_l;
    logic [CNT_W-1:0] r_n, n_eff;
    logic [IDX_W-1:0] n_m1;
    t_tok r_t0;
    t_tok toks [MAX_N+1];
    t_res [MAX_N-1:0] res;
    t_out post_out;
    logic en, in_acc, load_ok, out_acc;
    logic [IDX_W-1:0] ld_row, ld_col;
    logic [ADDR_W-1:0] ld_addr, c_raddr, c_waddr_p, c_waddr;
    logic [DATA_W-1:0] a_rdata, c_rdata, c_wdata_p, c_wdata;
    logic c_we_p, c_we;

    assign en      = !(post_out.valid && i_stall);
    assign o_stall = r_busy;
    assign in_acc  = i_valid && !r_busy;
    assign out_acc = post_out.valid && !i_stall;
    assign load_ok = (6'(i_row_index) < 6'(MAX_N)) && (6'(i_col_index) < 6'(MAX_N));
    assign ld_row  = IDX_W'(i_row_index);
    assign ld_col  = IDX_W'(i_col_index);
    assign ld_addr = elem_addr(ld_row, ld_col);
    assign n_m1    = IDX_W'(r_n - CNT_W'(1));

    always_comb begin
        if (r_size == 4'd0) begin
            n_eff = CNT_W'(1);
        end else if (5'(r_size) > 5'(MAX_N)) begin
            n_eff = CNT_W'(MAX_N);
        end else begin
            n_eff = CNT_W'(r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 4'd8;
            r_alpha <= 16'sd256;
            r_beta  <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SIZE:  r_size  <= i_cfg_data[3:0];
                REG_ALPHA: r_alpha <= i_cfg_data;
                REG_BETA:  r_beta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand sequencer: walks row i, inner index l
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_iss      <= 1'b0;
            r_t0.valid <= 1'b0;
        end else begin
            if (in_acc && i_command == CMD_START) begin
                r_busy <= 1'b1;
                r_iss  <= 1'b1;
                r_i    <= '0;
                r_l    <= '0;
                r_n    <= n_eff;
            end else if (out_acc && post_out.last) begin
                r_busy <= 1'b0;
            end
            if (en) begin
                r_t0.valid <= r_iss;
                r_t0.first <= r_l == '0;
                r_t0.last  <= r_l == n_m1;
                r_t0.row   <= r_i;
                r_t0.k     <= r_l;
                r_t0.a     <= '0;
                if (r_iss) begin
                    if (r_l == n_m1) begin
                        r_l <= '0;
                        if (r_i == n_m1) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_i <= r_i + IDX_W'(1);
                        end
                    end else begin
                        r_l <= r_l + IDX_W'(1);
                    end
                end
            end
        end
    end

    smma_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N * MAX_N)) u_a_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && i_command == CMD_LOAD_A && load_ok),
        .i_waddr(ld_addr),
        .i_wdata(i_element_value),
        .i_re   (en),
        .i_raddr(elem_addr(r_i, r_l)),
        .o_rdata(a_rdata)
    );

    always_comb begin
        toks[0]   = r_t0;
        toks[0].a = $signed(a_rdata);
    end

    for (genvar j = 0; j < MAX_N; j++) begin : g_cell
        smma_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_col  (IDX_W'(j)),
            .i_n    (r_n),
            .i_tok  (toks[j]),
            .o_tok  (toks[j+1]),
            .i_bwe  (in_acc && i_command == CMD_LOAD_B && load_ok && ld_col == IDX_W'(j)),
            .i_baddr(ld_row),
            .i_bdata(i_element_value),
            .o_res  (res[j])
        );
    end

    smma_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_res    (res),
        .i_alpha  (r_alpha),
        .i_beta   (r_beta),
        .o_c_raddr(c_raddr),
        .i_c_rdata(c_rdata),
        .o_c_we   (c_we_p),
        .o_c_waddr(c_waddr_p),
        .o_c_wdata(c_wdata_p),
        .o_out    (post_out)
    );

    // loads only arrive while no compute is in flight
    assign c_we    = c_we_p || (in_acc && i_command == CMD_LOAD_C && load_ok);
    assign c_waddr = c_we_p ? c_waddr_p : ld_addr;
    assign c_wdata = c_we_p ? c_wdata_p : i_element_value;

    smma_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N * MAX_N)) u_c_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (en),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    assign o_valid     = post_out.valid;
    assign o_out_row   = 3'(post_out.row);
    assign o_out_col   = 3'(post_out.col);
    assign o_out_value = post_out.value;
    assign o_out_last  = post_out.last;
endmodule
